>>> sv/tol_pkg.sv
package tol_pkg;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 184;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd4;

  // Datapath widths
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned XW = 45;       // CORDIC x/y
  localparam int unsigned ZW = 35;       // CORDIC angle, Q30 rad
  localparam int unsigned MW = 36;       // multiplier operand
  localparam int unsigned PW = 2 * MW;   // multiplier product
  localparam int unsigned QW = 31;       // divider quotient bits and steps
  localparam int unsigned DW = 34;       // divider divisor and remainder
  localparam int unsigned PN = 37;       // unsaturated point coordinate

  localparam logic signed [ZW-1:0] PI_Q30         = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30    = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30     = 35'sd6746518852;
  localparam logic signed [ZW-1:0] THREE_HALF_PI  = 35'sd5059889139;
  localparam logic signed [XW-1:0] GAIN_Q30       = 45'sd652032874;
  localparam logic signed [XW-1:0] NORM_LIMIT     = 45'sd1099511627776;
  localparam logic signed [MW-1:0] Q30_ONE        = 36'sd1073741824;
  localparam logic signed [MW-1:0] RAD_TO_DEG_Q24 = 36'sd961263670;
  localparam logic signed [PW-1:0] DEG_LIMIT      = 72'sd16777215;
  localparam logic signed [PW-1:0] DOT_LIMIT      = 72'sd4294967295;

  typedef struct packed {
    logic start;
    logic vec;     // 1 = vectoring (atan), 0 = rotation (sin/cos)
  } cor_cmd_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837830;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097150;
      5'd10: v = 35'sd1048576;
      5'd11: v = 35'sd524288;
      5'd12: v = 35'sd262144;
      5'd13: v = 35'sd131072;
      5'd14: v = 35'sd65536;
      5'd15: v = 35'sd32768;
      5'd16: v = 35'sd16384;
      5'd17: v = 35'sd8192;
      5'd18: v = 35'sd4096;
      5'd19: v = 35'sd2048;
      5'd20: v = 35'sd1024;
      5'd21: v = 35'sd512;
      5'd22: v = 35'sd256;
      5'd23: v = 35'sd128;
      5'd24: v = 35'sd64;
      5'd25: v = 35'sd32;
      5'd26: v = 35'sd16;
      5'd27: v = 35'sd8;
      5'd28: v = 35'sd4;
      5'd29: v = 35'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/tag_offset_point_locator.sv
// Channel | Dir | Bits                      | Beat taken when
// in_*    | in  | tdata 208, tuser 1, tlast | in_tvalid & in_tready
// out_*   | out | tdata 184, tuser 1        | out_tvalid & out_tready
// cfg_*   | in  | index 3, data 32          | cfg_valid & cfg_ready
// A beat that gives no result is taken in ST_IDLE; a closing miss also passes through ST_EMIT.
// A matching beat with a nonzero angle takes four divider passes, two square roots, a
// sin/cos CORDIC, up to two bearing CORDIC runs with up to 40 normalize shifts each, and
// 27 products through the one multiplier; at zero angle the divider passes, the sin/cos
// CORDIC and the rotation products are skipped.
// in_tready is low from a beat that needs a result until that result is loaded into the
// output register; a full output register that is not drained holds that load.
// Reset is synchronous; cfg_ready is always high.
module tag_offset_point_locator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // det_id[9:0], rot_vec_x/y/z[105:10], trans_x/y/z[201:106], zero pad
  input  logic [tol_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,   // pose_known
  input  logic                               in_tlast,   // last_det
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // point_x/y/z[95:0], point_range[126:96], bearing_h[151:127], bearing_v[176:152], pad
  output logic [tol_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,  // hit
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tol_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tol_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tol_pkg::*;

  localparam int ANG_SHIFT = 30 - FRAC_BITS;
  localparam int DEG_SHIFT = 54 - FRAC_BITS;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQ   = 9'b000000010,
    ST_ROOT = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_ROT  = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_ATAN = 9'b001000000,
    ST_DEG  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  function automatic logic [32:0] mag32(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    return v[31] ? 33'(-w) : 33'(w);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PN-1:0] v);
    if (v > PN'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < PN'(-32'sh7fffffff - 32'sd1)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [XW-1:0] v);
    if (v > XW'(Q30_ONE)) return 32'sd1073741824;
    if (v < -XW'(Q30_ONE)) return -32'sd1073741824;
    return v[31:0];
  endfunction

  function automatic logic signed [24:0] clamp_deg(input logic signed [PW-1:0] v);
    if (v > DEG_LIMIT) return DEG_LIMIT[24:0];
    if (v < -DEG_LIMIT) return 25'(-DEG_LIMIT);
    return v[24:0];
  endfunction

  // control
  state_t     state_r;
  logic [5:0] step_r;
  logic       kick_r, pass_r, matched_r, hit_r, out_valid_r;

  // configuration
  logic              en_r;
  logic [9:0]        tgt_r;
  logic signed [31:0] off_r [3];

  // datapath
  logic signed [31:0]    r_r [3];
  logic signed [31:0]    t_r [3];
  logic signed [31:0]    k_r [3];
  logic signed [33:0]    cr_r [3];
  logic signed [PN-1:0]  p_r [3];
  logic [31:0]           theta_r;
  logic signed [31:0]    c_r, s_r;
  logic signed [33:0]    dot_r;
  logic signed [34:0]    e_r;
  logic signed [PW-1:0]  acc_r;
  logic [63:0]           sq_r;
  logic [30:0]           range_r;
  logic signed [ZW-1:0]  zh_r, zv_r;
  logic signed [24:0]    bh_r, bv_r;
  logic signed [31:0]    ox_r, oy_r, oz_r;
  logic [30:0]           orng_r;
  logic signed [24:0]    obh_r, obv_r;
  logic                  ohit_r;

  logic                  in_fire, match, out_free;
  logic [9:0]            in_id;
  logic signed [31:0]    in_rot [3];
  logic signed [31:0]    in_trans [3];
  logic signed [31:0]    pc [3];
  logic [4:0]            op;
  logic [1:0]            sqj;
  logic [32:0]           sq_opnd;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_p, sh30, shdeg;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic [63:0] sqrt_din;

  logic          div_start, div_done;
  logic [63:0]   div_dividend;
  logic [DW-1:0] div_divisor, div_rem;
  logic [QW-1:0] div_quot;
  logic [1:0]    divj;

  cor_cmd_t             cor_cmd;
  logic                 cor_done;
  logic signed [XW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;
  logic signed [31:0]   at_a, at_b;
  logic                 at_zero;

  assign in_id = in_tdata[9:0];
  for (genvar g = 0; g < 3; g++) begin : g_unpack
    assign in_rot[g]   = in_tdata[10 + 32*g +: 32];
    assign in_trans[g] = in_tdata[106 + 32*g +: 32];
    assign pc[g]       = sat32(p_r[g]);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign match     = !matched_r && en_r && (in_id == tgt_r) && in_tuser;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign op    = step_r[5:1];
  assign sqj   = step_r[2:1];
  assign divj  = step_r[1:0];
  assign sh30  = mul_p >>> 30;
  assign shdeg = mul_p >>> DEG_SHIFT;

  assign sq_opnd = pass_r ? mag32(pc[sqj]) : mag32(r_r[sqj]);

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQ) begin
      mul_a = MW'(sq_opnd);
      mul_b = MW'(sq_opnd);
    end else if (state_r == ST_MUL) begin
      unique case (op)
        5'd0:  begin mul_a = MW'(k_r[0]); mul_b = MW'(off_r[0]); end
        5'd1:  begin mul_a = MW'(k_r[1]); mul_b = MW'(off_r[1]); end
        5'd2:  begin mul_a = MW'(k_r[2]); mul_b = MW'(off_r[2]); end
        5'd3:  begin mul_a = Q30_ONE - MW'(c_r); mul_b = MW'(dot_r); end
        5'd4:  begin mul_a = MW'(k_r[1]); mul_b = MW'(off_r[2]); end
        5'd5:  begin mul_a = MW'(k_r[2]); mul_b = MW'(off_r[1]); end
        5'd6:  begin mul_a = MW'(k_r[2]); mul_b = MW'(off_r[0]); end
        5'd7:  begin mul_a = MW'(k_r[0]); mul_b = MW'(off_r[2]); end
        5'd8:  begin mul_a = MW'(k_r[0]); mul_b = MW'(off_r[1]); end
        5'd9:  begin mul_a = MW'(k_r[1]); mul_b = MW'(off_r[0]); end
        5'd10: begin mul_a = MW'(c_r);    mul_b = MW'(off_r[0]); end
        5'd11: begin mul_a = MW'(e_r);    mul_b = MW'(k_r[0]); end
        5'd12: begin mul_a = MW'(s_r);    mul_b = MW'(cr_r[0]); end
        5'd13: begin mul_a = MW'(c_r);    mul_b = MW'(off_r[1]); end
        5'd14: begin mul_a = MW'(e_r);    mul_b = MW'(k_r[1]); end
        5'd15: begin mul_a = MW'(s_r);    mul_b = MW'(cr_r[1]); end
        5'd16: begin mul_a = MW'(c_r);    mul_b = MW'(off_r[2]); end
        5'd17: begin mul_a = MW'(e_r);    mul_b = MW'(k_r[2]); end
        5'd18: begin mul_a = MW'(s_r);    mul_b = MW'(cr_r[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == ST_DEG) begin
      mul_a = step_r[1] ? MW'(zv_r) : MW'(zh_r);
      mul_b = RAD_TO_DEG_Q24;
    end
  end

  // divider operands: three unit-vector components, then the angle reduction
  always_comb begin
    if (divj == 2'd3) begin
      div_dividend = 64'(theta_r) << ANG_SHIFT;
      div_divisor  = DW'(TWO_PI_Q30);
    end else begin
      div_dividend = {1'b0, mag32(r_r[divj]), 30'b0};
      div_divisor  = DW'(theta_r);
    end
  end

  assign at_a    = step_r[0] ? pc[1] : pc[0];
  assign at_b    = pc[2];
  assign at_zero = (at_a == 0) && (at_b == 0);

  always_comb begin
    if (state_r == ST_ROT) begin
      cor_x0 = GAIN_Q30;
      cor_y0 = '0;
      cor_z0 = ZW'({1'b0, div_rem});
    end else begin
      cor_x0 = XW'(at_b);
      cor_y0 = XW'(at_a);
      cor_z0 = '0;
    end
  end

  assign sqrt_start    = kick_r && (state_r == ST_ROOT);
  assign sqrt_din      = sq_r;
  assign div_start     = kick_r && (state_r == ST_DIV);
  assign cor_cmd.start = kick_r && ((state_r == ST_ROT) || (state_r == ST_ATAN && !at_zero));
  assign cor_cmd.vec   = (state_r == ST_ATAN);

  tol_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tol_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .din   (sqrt_din),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  tol_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  tol_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cor_cmd),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      kick_r      <= 1'b0;
      pass_r      <= 1'b0;
      matched_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      tgt_r       <= '0;
      off_r[0]    <= '0;
      off_r[1]    <= '0;
      off_r[2]    <= '0;
    end else begin
      kick_r <= 1'b0;
      if (out_tready && !(state_r == ST_EMIT && out_free)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ENABLE:   en_r     <= cfg_data[0];
          REG_TAG_ID:   tgt_r    <= cfg_data[9:0];
          REG_OFFSET_X: off_r[0] <= cfg_data;
          REG_OFFSET_Y: off_r[1] <= cfg_data;
          REG_OFFSET_Z: off_r[2] <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            matched_r <= in_tlast ? 1'b0 : (matched_r || match);
            if (match) begin
              for (int j = 0; j < 3; j++) begin
                r_r[j] <= in_rot[j];
                t_r[j] <= in_trans[j];
              end
              hit_r   <= 1'b1;
              pass_r  <= 1'b0;
              sq_r    <= '0;
              step_r  <= '0;
              state_r <= ST_SQ;
            end else if (in_tlast && !matched_r) begin
              hit_r   <= 1'b0;
              state_r <= ST_EMIT;
            end
          end
        end

        ST_SQ: begin
          step_r <= step_r + 6'd1;
          if (step_r[0]) begin
            sq_r <= sq_r + mul_p[63:0];
          end
          if (step_r == 6'd5) begin
            kick_r  <= 1'b1;
            state_r <= ST_ROOT;
          end
        end

        ST_ROOT: begin
          if (sqrt_done) begin
            step_r <= '0;
            if (pass_r) begin
              range_r <= sqrt_root[31] ? 31'h7fffffff : sqrt_root[30:0];
              kick_r  <= 1'b1;
              state_r <= ST_ATAN;
            end else if (sqrt_root == 0) begin
              // zero angle: identity rotation
              for (int j = 0; j < 3; j++) begin
                p_r[j] <= PN'(t_r[j]) + PN'(off_r[j]);
              end
              pass_r  <= 1'b1;
              sq_r    <= '0;
              state_r <= ST_SQ;
            end else begin
              theta_r <= sqrt_root;
              kick_r  <= 1'b1;
              state_r <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            if (divj == 2'd3) begin
              kick_r  <= 1'b1;
              state_r <= ST_ROT;
            end else begin
              k_r[divj] <= r_r[divj][31] ? -$signed({1'b0, div_quot})
                                         : $signed({1'b0, div_quot});
              step_r    <= step_r + 6'd1;
              kick_r    <= 1'b1;
            end
          end
        end

        ST_ROT: begin
          if (cor_done) begin
            c_r     <= clamp_q30(cor_x);
            s_r     <= clamp_q30(cor_y);
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end

        ST_MUL: begin
          step_r <= step_r + 6'd1;
          if (step_r[0]) begin
            unique case (op)
              5'd0:  acc_r <= sh30;
              5'd1:  acc_r <= acc_r + sh30;
              5'd2: begin
                if (acc_r + sh30 > DOT_LIMIT) dot_r <= DOT_LIMIT[33:0];
                else if (acc_r + sh30 < -DOT_LIMIT) dot_r <= 34'(-DOT_LIMIT);
                else dot_r <= 34'(acc_r + sh30);
              end
              5'd3:  e_r <= sh30[34:0];
              5'd4, 5'd6, 5'd8: acc_r <= mul_p;
              5'd5:  cr_r[0] <= 34'((acc_r - mul_p) >>> 30);
              5'd7:  cr_r[1] <= 34'((acc_r - mul_p) >>> 30);
              5'd9:  cr_r[2] <= 34'((acc_r - mul_p) >>> 30);
              5'd10: p_r[0] <= PN'(t_r[0]) + PN'(sh30);
              5'd13: p_r[1] <= PN'(t_r[1]) + PN'(sh30);
              5'd16: p_r[2] <= PN'(t_r[2]) + PN'(sh30);
              5'd11, 5'd12: p_r[0] <= p_r[0] + PN'(sh30);
              5'd14, 5'd15: p_r[1] <= p_r[1] + PN'(sh30);
              5'd17, 5'd18: p_r[2] <= p_r[2] + PN'(sh30);
              default: ;
            endcase
            if (op == 5'd18) begin
              pass_r  <= 1'b1;
              sq_r    <= '0;
              step_r  <= '0;
              state_r <= ST_SQ;
            end
          end
        end

        ST_ATAN: begin
          if ((kick_r && at_zero) || cor_done) begin
            if (step_r[0]) zv_r <= cor_done ? cor_z : '0;
            else           zh_r <= cor_done ? cor_z : '0;
            if (step_r[0]) begin
              step_r  <= '0;
              state_r <= ST_DEG;
            end else begin
              step_r <= 6'd1;
              kick_r <= 1'b1;
            end
          end
        end

        ST_DEG: begin
          step_r <= step_r + 6'd1;
          if (step_r[0]) begin
            if (step_r[1]) bv_r <= -clamp_deg(shdeg);
            else           bh_r <= clamp_deg(shdeg);
          end
          if (step_r == 6'd3) begin
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            ohit_r      <= hit_r;
            ox_r        <= hit_r ? pc[0] : '0;
            oy_r        <= hit_r ? pc[1] : '0;
            oz_r        <= hit_r ? pc[2] : '0;
            orng_r      <= hit_r ? range_r : '0;
            obh_r       <= hit_r ? bh_r : '0;
            obv_r       <= hit_r ? bv_r : '0;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ohit_r;
  assign out_tdata  = {7'b0, obv_r, obh_r, orng_r, oz_r, oy_r, ox_r};

  // A miss beat carries nothing but zeros
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result with nonzero payload");

  // The list state is cleared after every closing beat
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !matched_r)
    else $error("match flag survived the last beat");

  // Bearings stay inside the degree limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (PW'(obh_r) <= DEG_LIMIT) && (PW'(obh_r) >= -DEG_LIMIT) &&
                   (PW'(obv_r) <= DEG_LIMIT) && (PW'(obv_r) >= -DEG_LIMIT))
    else $error("bearing out of range");

  // No new beat is taken while the arithmetic units hold an item
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted during computation");

endmodule

>>> sv/tol_mul.sv
module tol_mul (
  input  logic                              clk,
  input  logic signed [tol_pkg::MW-1:0]     a,
  input  logic signed [tol_pkg::MW-1:0]     b,
  output logic signed [tol_pkg::PW-1:0]     p
);
  import tol_pkg::*;

  logic signed [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

>>> sv/tol_isqrt.sv
module tol_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] din,
  output logic        done,
  output logic [31:0] root
);
  import tol_pkg::*;

  logic [63:0] n_r, r_r, bit_r;
  logic [63:0] trial;
  logic        busy_r, done_r;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= din;
        r_r    <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (n_r >= trial) begin
          n_r <= n_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

>>> sv/tol_div.sv
module tol_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            dividend,
  input  logic [tol_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [tol_pkg::QW-1:0] quot,
  output logic [tol_pkg::DW-1:0] rem
);
  import tol_pkg::*;

  logic [DW-1:0] rem_r;
  logic [QW-1:0] lo_r, quot_r;
  logic [4:0]    cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;
  logic          ge;

  // Quotient stays below 2^QW, so the top bits start as the partial remainder
  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= DW'(dividend[63:QW]);
        lo_r   <= dividend[QW-1:0];
        quot_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
        lo_r   <= lo_r << 1;
        quot_r <= {quot_r[QW-2:0], ge};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

>>> sv/tol_cordic.sv
module tol_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tol_pkg::cor_cmd_t             cmd,
  input  logic signed [tol_pkg::XW-1:0] x0,
  input  logic signed [tol_pkg::XW-1:0] y0,
  input  logic signed [tol_pkg::ZW-1:0] z0,
  output logic                          done,
  output logic signed [tol_pkg::XW-1:0] x,
  output logic signed [tol_pkg::XW-1:0] y,
  output logic signed [tol_pkg::ZW-1:0] z
);
  import tol_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_PREP = 5'b00010,
    PH_NORM = 5'b00100,
    PH_RUN  = 5'b01000,
    PH_FIX  = 5'b10000
  } phase_t;

  phase_t               phase_r;
  logic signed [XW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r;
  logic [4:0]           i_r;
  logic                 vec_r, neg_r, ypos_r, done_r;
  logic                 dpos, grow;

  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign dpos  = vec_r ? (y_r <= 0) : (z_r >= 0);
  assign grow  = (x_r > -NORM_LIMIT) && (x_r < NORM_LIMIT) &&
                 (y_r > -NORM_LIMIT) && (y_r < NORM_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
      i_r     <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (cmd.start) begin
            x_r     <= x0;
            y_r     <= y0;
            z_r     <= z0;
            vec_r   <= cmd.vec;
            neg_r   <= 1'b0;
            ypos_r  <= y0 >= 0;
            i_r     <= '0;
            phase_r <= cmd.vec ? PH_NORM : PH_PREP;
          end
        end
        PH_PREP: begin
          // fold the angle into [-pi/2, pi/2], flip the result later
          if (z_r > HALF_PI_Q30 && z_r < THREE_HALF_PI) begin
            z_r   <= z_r - PI_Q30;
            neg_r <= 1'b1;
          end else if (z_r >= THREE_HALF_PI) begin
            z_r <= z_r - TWO_PI_Q30;
          end
          phase_r <= PH_RUN;
        end
        PH_NORM: begin
          if (grow) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            if (x_r < 0) begin
              z_r <= ypos_r ? PI_Q30 : -PI_Q30;
              x_r <= -x_r;
              y_r <= -y_r;
            end
            phase_r <= PH_RUN;
          end
        end
        PH_RUN: begin
          if (dpos) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_q30(i_r);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_q30(i_r);
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(CORDIC_STEPS - 1)) begin
            phase_r <= PH_FIX;
          end
        end
        PH_FIX: begin
          if (!vec_r && neg_r) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
          done_r  <= 1'b1;
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tol_pkg::*;

  localparam int FB = 16;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_K = 64'sd3373259426;
  localparam longint HPI_K = 64'sd1686629713;
  localparam longint TWO_PI_K = 64'sd6746518852;
  localparam longint GAIN_K = 64'sd652032874;
  localparam longint DEG_K = 64'sd961263670;
  localparam longint DEG_MAX = 64'sd16777215;
  localparam longint DOT_MAX = 64'sd4294967295;
  localparam longint ANGLE_TAB [30] = '{
    843314857, 497837830, 263043837, 133525159, 67021687,
    33543515, 16775851, 8388437, 4194283, 2097150,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    bit [9:0] id;
    bit pose;
    bit last;
    logic signed [31:0] rv [3];
    logic signed [31:0] tr [3];
  } det_t;

  typedef struct {
    bit hit;
    logic signed [31:0] pt [3];
    logic [30:0] rng;
    logic [24:0] bh;
    logic [24:0] bv;
  } spot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tag_offset_point_locator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and list state
  bit pr_en;
  bit [9:0] pr_tag;
  longint pr_off [3];
  bit pr_matched;

  spot_t spots_due [$];
  int errors, hits_seen, misses_seen, dets_sent;
  bit quiet;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned absv(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void sincos(longint unsigned th, output longint c, output longint s);
    longint a, x, y, xs, ys;
    bit flip;
    a = longint'((th << (30 - FB)) % longint'(TWO_PI_K));
    x = GAIN_K;
    y = 0;
    flip = 0;
    if (a > PI_K) a -= TWO_PI_K;
    if (a > HPI_K) begin
      a -= PI_K;
      flip = 1;
    end else if (a < -HPI_K) begin
      a += PI_K;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= ANGLE_TAB[i];
      end else begin
        x += ys; y -= xs; a += ANGLE_TAB[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -ONE_Q30, ONE_Q30);
    s = clip(y, -ONE_Q30, ONE_Q30);
  endfunction

  function automatic longint bearing_deg(longint a, longint b);
    longint x, y, z, xs, ys;
    if (a == 0 && b == 0) return 0;
    x = b;
    y = a;
    z = 0;
    while (absv(x) < (64'd1 << 40) && absv(y) < (64'd1 << 40)) begin
      x = x * 2; y = y * 2;
    end
    if (x < 0) begin
      z = (a >= 0) ? PI_K : -PI_K;
      x = -x; y = -y;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ANGLE_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ANGLE_TAB[i];
      end
    end
    return clip((z * DEG_K) >>> (54 - FB), -DEG_MAX, DEG_MAX);
  endfunction

  // advance the list state by one detection; returns 1 when a result is due
  function automatic bit locate_point(det_t d, output spot_t res);
    longint r [3], p [3], k [3], cr [3];
    longint c, s, dot, e;
    longint unsigned sq, th;
    bit due;
    due = 0;
    res.hit = 0;
    res.pt = '{0, 0, 0};
    res.rng = '0;
    res.bh = '0;
    res.bv = '0;
    if (!pr_matched && pr_en && d.id == pr_tag && d.pose) begin
      sq = 0;
      for (int j = 0; j < 3; j++) begin
        r[j] = d.rv[j];
        sq += absv(r[j]) * absv(r[j]);
      end
      th = root64(sq);
      if (th == 0) begin
        for (int j = 0; j < 3; j++) p[j] = longint'(d.tr[j]) + pr_off[j];
      end else begin
        for (int j = 0; j < 3; j++) k[j] = (r[j] * ONE_Q30) / longint'(th);
        sincos(th, c, s);
        dot = ((k[0] * pr_off[0]) >>> 30) + ((k[1] * pr_off[1]) >>> 30)
            + ((k[2] * pr_off[2]) >>> 30);
        dot = clip(dot, -DOT_MAX, DOT_MAX);
        e = ((ONE_Q30 - c) * dot) >>> 30;
        cr[0] = (k[1] * pr_off[2] - k[2] * pr_off[1]) >>> 30;
        cr[1] = (k[2] * pr_off[0] - k[0] * pr_off[2]) >>> 30;
        cr[2] = (k[0] * pr_off[1] - k[1] * pr_off[0]) >>> 30;
        for (int j = 0; j < 3; j++)
          p[j] = longint'(d.tr[j]) + ((c * pr_off[j]) >>> 30) + ((e * k[j]) >>> 30)
               + ((s * cr[j]) >>> 30);
      end
      sq = 0;
      for (int j = 0; j < 3; j++) begin
        p[j] = clip(p[j], -64'sd2147483648, 64'sd2147483647);
        sq += absv(p[j]) * absv(p[j]);
        res.pt[j] = p[j][31:0];
      end
      th = root64(sq);
      if (th > 64'h7fffffff) th = 64'h7fffffff;
      res.hit = 1;
      res.rng = th[30:0];
      res.bh = 25'(bearing_deg(p[0], p[2]));
      res.bv = 25'(-bearing_deg(p[1], p[2]));
      pr_matched = 1;
      due = 1;
    end
    if (d.last) begin
      if (!pr_matched) due = 1;
      pr_matched = 0;
    end
    return due;
  endfunction

  // result checker
  always @(posedge clk) begin
    spot_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (spots_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = spots_due.pop_front();
        if (out_tuser !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_tuser);
          errors++;
        end
        for (int j = 0; j < 3; j++)
          if (out_tdata[32*j +: 32] !== want.pt[j]) begin
            $error("point[%0d]: expected %0d, got %0d", j, want.pt[j],
                   $signed(out_tdata[32*j +: 32]));
            errors++;
          end
        if (out_tdata[126:96] !== want.rng) begin
          $error("point_range: expected %0d, got %0d", want.rng, out_tdata[126:96]);
          errors++;
        end
        if (out_tdata[151:127] !== want.bh) begin
          $error("bearing_h: expected %0d, got %0d", $signed(want.bh),
                 $signed(out_tdata[151:127]));
          errors++;
        end
        if (out_tdata[176:152] !== want.bv) begin
          $error("bearing_v: expected %0d, got %0d", $signed(want.bv),
                 $signed(out_tdata[176:152]));
          errors++;
        end
        if (want.hit) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_det(det_t d);
    spot_t res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, d.tr[2], d.tr[1], d.tr[0], d.rv[2], d.rv[1], d.rv[0], d.id};
    in_tuser <= d.pose;
    in_tlast <= d.last;
    do @(posedge clk); while (!in_tready);
    dets_sent++;
    if (locate_point(d, res)) spots_due = {spots_due, res};
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (spots_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:   pr_en = val[0];
      REG_TAG_ID:   pr_tag = val[9:0];
      REG_OFFSET_X: pr_off[0] = longint'($signed(val));
      REG_OFFSET_Y: pr_off[1] = longint'($signed(val));
      REG_OFFSET_Z: pr_off[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic setup(bit en, bit [9:0] tag, logic [31:0] ox, logic [31:0] oy,
                       logic [31:0] oz);
    drain();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_TAG_ID, {22'd0, tag});
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
  endtask

  function automatic det_t mk(bit [9:0] id, bit pose, bit last, logic [31:0] rx,
                              logic [31:0] ry, logic [31:0] rz, logic [31:0] tx,
                              logic [31:0] ty, logic [31:0] tz);
    det_t d;
    d.id = id; d.pose = pose; d.last = last;
    d.rv = '{rx, ry, rz};
    d.tr = '{tx, ty, tz};
    return d;
  endfunction

  function automatic logic [31:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // disabled: every list ends in a miss
    setup(0, 10'd5, 32'h10000, 0, 0);
    send_det(mk(10'd5, 1, 0, 0, 0, 0, 1, 2, 3));
    send_det(mk(10'd5, 1, 1, 0, 0, 0, 1, 2, 3));
    setup(1, 10'd1023, 32'h10000, 32'h20000, 32'h30000);
    // zero angle gives trans + offset
    send_det(mk(10'd1023, 1, 1, 0, 0, 0, 32'h50000, 0, 32'h100000));
    // pose unknown, wrong id, then a match on the last item
    send_det(mk(10'd1023, 0, 0, 32'h10000, 0, 0, 1, 1, 1));
    send_det(mk(10'd0, 1, 0, 32'h10000, 0, 0, 1, 1, 1));
    send_det(mk(10'd1023, 1, 1, 32'h1921f, 0, 0, 0, 0, 32'h10000));
    // later matches in a matched list are dropped
    send_det(mk(10'd1023, 1, 0, 0, 32'h8000, 0, 0, 0, 32'h20000));
    send_det(mk(10'd1023, 1, 0, 0, 0, 32'h30000, 5, 6, 7));
    send_det(mk(10'd1023, 1, 1, 32'h10000, 32'h10000, 32'h10000, 5, 6, 7));
    // both bearing operands zero
    send_det(mk(10'd1023, 1, 1, 0, 0, 0, 32'hffff0000, 32'hfffe0000, 32'hfffd0000));
    // field extremes and saturation
    send_det(mk(10'd1023, 1, 1, mx, mx, mx, mx, mx, mx));
    send_det(mk(10'd1023, 1, 1, mn, mn, mn, mn, mn, mn));
    send_det(mk(10'd1023, 1, 1, mx, mn, 0, mn, mx, 0));
    setup(1, 10'd0, mx, mn, mx);
    send_det(mk(10'd0, 1, 1, 0, 0, 0, mx, mx, mx));
    send_det(mk(10'd0, 1, 1, mn, mx, mn, mx, mn, mx));
    send_det(mk(10'd0, 1, 1, 32'h3243f, 0, 0, 0, 0, 0));
    setup(1, 10'd0, mn, mn, mn);
    send_det(mk(10'd0, 1, 1, 0, 32'h10000, 0, mn, mn, mn));
    // unused register indexes are ignored
    drain();
    write_reg(3'd5, 32'hffffffff);
    write_reg(3'd6, 32'h0);
    write_reg(3'd7, 32'h12345678);
    send_det(mk(10'd0, 1, 1, 32'h20000, 32'h1000, mx, 32'h10000, 0, 32'h40000));
  endtask

  task automatic test_lists(int n_dets);
    det_t d;
    int len, sent;
    sent = 0;
    while (sent < n_dets) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        d.last = (i == len - 1);
        d.id = ($urandom_range(0, 9) < 6) ? pr_tag : 10'($urandom_range(0, 1023));
        d.pose = ($urandom_range(0, 7) != 0);
        for (int j = 0; j < 3; j++) begin
          d.rv[j] = rand_rot();
          d.tr[j] = rand_len();
        end
        send_det(d);
        sent++;
      end
    end
  endtask

  initial begin
    pr_off = '{0, 0, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setup(1, 10'($urandom_range(0, 1023)), 0, 0, 0);
        1: setup(1, 10'd1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        2: setup(1, 10'd0, 32'h80000000, 32'h80000000, 32'h80000000);
        3: setup(0, 10'($urandom_range(0, 1023)), $urandom, $urandom, $urandom);
        default: setup(1, 10'($urandom_range(0, 1023)), rand_len(), rand_len(),
                       rand_len());
      endcase
      if (ph == 7) quiet = 1;
      test_lists(110);
      // wait out every result once mid-run
      if (ph == 4) drain();
    end
    drain();
    repeat (500) @(posedge clk);
    $display("covered %0d detections: %0d hits and %0d misses checked", dets_sent,
             hits_seen, misses_seen);
    $display("configs swept: disabled, extreme offsets, ids 0 and 1023, random offsets");
    if (errors == 0 && spots_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
sv/tol_pkg.sv
sv/tol_mul.sv
sv/tol_isqrt.sv
sv/tol_div.sv
sv/tol_cordic.sv
sv/tag_offset_point_locator.sv
bench/tb_top.sv
